// ===== rtl/core/rrc_pkg.sv =====
// rrc_pkg: shared types, codes and constants of the rectangle raster canvas
// depends on nothing; imported by every module of the block but rrc_ram
package rrc_pkg;

  // default configuration of the block
  localparam int DEFAULT_MAX_SIDE  = 512;
  localparam int DEFAULT_FRAC_BITS = 8;

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_CHAR = 2'd2;
  localparam logic [9:0] RESET_CANVAS_WIDTH  = 10'd300;
  localparam logic [9:0] RESET_CANVAS_HEIGHT = 10'd300;
  localparam logic [7:0] RESET_BACKGROUND    = 8'd32;

  // command codes
  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_DRAW  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // shape codes
  localparam logic [7:0] SHAPE_OUTLINE = 8'h72;  // 'r'
  localparam logic [7:0] SHAPE_FILLED  = 8'h52;  // 'R'

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DRAW_FAIL = 2'd1;
  localparam logic [1:0] ST_READ_OUT  = 2'd2;

  // depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         shape_code;
    logic signed [19:0] rect_left;
    logic signed [19:0] rect_top;
    logic [18:0]        rect_span_x;
    logic [18:0]        rect_span_y;
    logic [7:0]         paint_char;
    logic [8:0]         cell_column;
    logic [8:0]         cell_row;
  } rrc_in_t;

  typedef struct packed {
    logic [7:0] cell_value;
    logic [1:0] status;
    logic       error_seen;
  } rrc_out_t;

  // work handed from the front to the back
  typedef enum logic [1:0] {
    OP_REPLY,  // answer at once, no canvas access
    OP_FILL,   // sweep the active area with the background byte
    OP_DRAW,   // sweep the active area and paint covered cells
    OP_READ    // fetch one cell
  } rrc_op_t;

  typedef struct packed {
    rrc_op_t            op;
    logic [1:0]         status;
    logic               error_seen;
    logic               outline;
    logic [7:0]         paint_char;
    logic signed [19:0] rect_left;
    logic signed [19:0] rect_top;
    logic [18:0]        rect_span_x;
    logic [18:0]        rect_span_y;
    logic [8:0]         cell_column;
    logic [8:0]         cell_row;
  } rrc_cmd_t;

endpackage

// ===== rtl/core/rrc_ram.sv =====
// rrc_ram: generic single write port, single read port ram with registered read
// depends on nothing
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rrc_fifo.sv =====
// rrc_fifo: short command queue between front and back
// depends on rrc_pkg (rrc_cmd_t, QUEUE_DEPTH)
module rrc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrc_pkg::rrc_cmd_t push_cmd,
  input  logic              pop,
  output rrc_pkg::rrc_cmd_t head,
  output logic              empty,
  output logic              full
);
  import rrc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  rrc_cmd_t        slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/core/rrc_front.sv =====
// rrc_front: accepts commands, checks them and tracks the sticky draw error
// depends on rrc_pkg (rrc_in_t, rrc_cmd_t, codes)
module rrc_front #(
  parameter int MAX_SIDE = rrc_pkg::DEFAULT_MAX_SIDE,
  localparam int CNT_W = $clog2(MAX_SIDE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rrc_pkg::rrc_in_t  in_item,
  input  logic [CNT_W-1:0]  act_w,
  input  logic [CNT_W-1:0]  act_h,
  input  logic              q_full,
  output logic              q_push,
  output rrc_pkg::rrc_cmd_t q_cmd
);
  import rrc_pkg::*;

  logic draw_failed_r, draw_failed_nxt;
  logic shape_ok, read_out;

  assign q_push   = start && !q_full;
  assign shape_ok = (in_item.shape_code == SHAPE_OUTLINE) ||
                    (in_item.shape_code == SHAPE_FILLED);
  assign read_out = (32'(in_item.cell_column) >= 32'(act_w)) ||
                    (32'(in_item.cell_row) >= 32'(act_h));

  always_comb begin
    draw_failed_nxt      = draw_failed_r;
    q_cmd.op             = OP_REPLY;
    q_cmd.status         = ST_OK;
    q_cmd.outline        = (in_item.shape_code == SHAPE_OUTLINE);
    q_cmd.paint_char     = in_item.paint_char;
    q_cmd.rect_left      = in_item.rect_left;
    q_cmd.rect_top       = in_item.rect_top;
    q_cmd.rect_span_x    = in_item.rect_span_x;
    q_cmd.rect_span_y    = in_item.rect_span_y;
    q_cmd.cell_column    = in_item.cell_column;
    q_cmd.cell_row       = in_item.cell_row;
    unique case (in_item.func)
      FUNC_CLEAR: begin
        q_cmd.op        = OP_FILL;
        draw_failed_nxt = 1'b0;
      end
      FUNC_DRAW: begin
        if (draw_failed_r) begin
          q_cmd.status = ST_DRAW_FAIL;
        end else if (!shape_ok || in_item.rect_span_x == '0 ||
                     in_item.rect_span_y == '0) begin
          q_cmd.status    = ST_DRAW_FAIL;
          draw_failed_nxt = 1'b1;
        end else begin
          q_cmd.op = OP_DRAW;
        end
      end
      FUNC_READ: begin
        if (read_out) begin
          q_cmd.status = ST_READ_OUT;
        end else begin
          q_cmd.op = OP_READ;
        end
      end
      default: begin
        // unused code: plain ok answer
        q_cmd.op = OP_REPLY;
      end
    endcase
    q_cmd.error_seen = draw_failed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_failed_r <= 1'b0;
    end else if (q_push) begin
      draw_failed_r <= draw_failed_nxt;
    end
  end

endmodule

// ===== rtl/core/rrc_back.sv =====
// rrc_back: carries out queued commands: cell sweeps, reads and replies
// depends on rrc_pkg (rrc_cmd_t, rrc_out_t, codes)
module rrc_back #(
  parameter int MAX_SIDE  = rrc_pkg::DEFAULT_MAX_SIDE,
  parameter int FRAC_BITS = rrc_pkg::DEFAULT_FRAC_BITS,
  localparam int CNT_W = $clog2(MAX_SIDE + 1),
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CNT_W-1:0]  act_w,
  input  logic [CNT_W-1:0]  act_h,
  input  logic [7:0]        bg_char,
  input  rrc_pkg::rrc_cmd_t q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              ram_we,
  output logic [AW-1:0]     ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              ram_re,
  output logic [AW-1:0]     ram_raddr,
  input  logic [7:0]        ram_rdata,
  output logic              out_valid,
  output rrc_pkg::rrc_out_t out_item
);
  import rrc_pkg::*;

  localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW_A   = SIDE_W + FRAC_BITS + 2;
  localparam int CW     = (CW_A > 23) ? CW_A : 23;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_READ} state_t;

  state_t               state_r, state_nxt;
  logic [SIDE_W-1:0]    x_r, x_nxt;
  logic [SIDE_W-1:0]    y_r, y_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic                 fill_r, fill_nxt;
  logic                 outline_r, outline_nxt;
  logic [7:0]           paint_r, paint_nxt;
  logic [1:0]           stat_r, stat_nxt;
  logic                 err_r, err_nxt;
  logic signed [CW-1:0] l_r, l_nxt, r_r, r_nxt, l1_r, l1_nxt, r1_r, r1_nxt;
  logic signed [CW-1:0] t_r, t_nxt, b_r, b_nxt, t1_r, t1_nxt, b1_r, b1_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rrc_out_t             out_item_r, out_item_nxt;

  logic signed [CW-1:0] one_c, px, py, hl, ht;
  logic                 in_x, in_y, edge_x, edge_y, paint, last_x, last_y;
  logic [31:0]          rd_lin;

  assign one_c = CW'(1) << FRAC_BITS;
  assign px    = signed'(CW'(x_r) << FRAC_BITS);
  assign py    = signed'(CW'(y_r) << FRAC_BITS);
  assign hl    = CW'(signed'(q_head.rect_left));
  assign ht    = CW'(signed'(q_head.rect_top));

  // cell against the rectangle, each axis on its own
  assign in_x   = (px >= l_r) && (px <= r_r);
  assign in_y   = (py >= t_r) && (py <= b_r);
  assign edge_x = (px < l1_r) || (px > r1_r);
  assign edge_y = (py < t1_r) || (py > b1_r);
  assign paint  = fill_r || (in_x && in_y && (!outline_r || edge_x || edge_y));
  assign last_x = (CNT_W'(x_r) == act_w - CNT_W'(1));
  assign last_y = (CNT_W'(y_r) == act_h - CNT_W'(1));

  assign rd_lin    = 32'(q_head.cell_row) * 32'(MAX_SIDE) + 32'(q_head.cell_column);
  assign ram_raddr = rd_lin[AW-1:0];
  assign ram_waddr = base_r + AW'(x_r);
  assign ram_wdata = paint_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    base_nxt      = base_r;
    fill_nxt      = fill_r;
    outline_nxt   = outline_r;
    paint_nxt     = paint_r;
    stat_nxt      = stat_r;
    err_nxt       = err_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    l1_nxt        = l1_r;
    r1_nxt        = r1_r;
    t_nxt         = t_r;
    b_nxt         = b_r;
    t1_nxt        = t1_r;
    b1_nxt        = b1_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          stat_nxt = q_head.status;
          err_nxt  = q_head.error_seen;
          unique case (q_head.op)
            OP_READ: begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
            OP_FILL, OP_DRAW: begin
              if (act_w == '0 || act_h == '0) begin
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{cell_value: 8'd0, status: q_head.status,
                                  error_seen: q_head.error_seen};
              end else begin
                fill_nxt    = (q_head.op == OP_FILL);
                outline_nxt = q_head.outline;
                paint_nxt   = (q_head.op == OP_FILL) ? bg_char : q_head.paint_char;
                l_nxt       = hl;
                r_nxt       = hl + CW'(q_head.rect_span_x);
                l1_nxt      = hl + one_c;
                r1_nxt      = hl + CW'(q_head.rect_span_x) - one_c;
                t_nxt       = ht;
                b_nxt       = ht + CW'(q_head.rect_span_y);
                t1_nxt      = ht + one_c;
                b1_nxt      = ht + CW'(q_head.rect_span_y) - one_c;
                x_nxt       = '0;
                y_nxt       = '0;
                base_nxt    = '0;
                state_nxt   = S_WALK;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_item_nxt  = '{cell_value: 8'd0, status: q_head.status,
                                error_seen: q_head.error_seen};
            end
          endcase
        end
      end
      S_WALK: begin
        ram_we = paint;
        if (last_x) begin
          x_nxt = '0;
          if (last_y) begin
            y_nxt         = '0;
            base_nxt      = '0;
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{cell_value: 8'd0, status: stat_r, error_seen: err_r};
            state_nxt     = S_IDLE;
          end else begin
            y_nxt    = y_r + SIDE_W'(1);
            base_nxt = base_r + AW'(MAX_SIDE);
          end
        end else begin
          x_nxt = x_r + SIDE_W'(1);
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{cell_value: ram_rdata, status: stat_r, error_seen: err_r};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      x_r         <= '0;
      y_r         <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      x_r         <= x_nxt;
      y_r         <= y_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_r     <= fill_nxt;
    outline_r  <= outline_nxt;
    paint_r    <= paint_nxt;
    stat_r     <= stat_nxt;
    err_r      <= err_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    l1_r       <= l1_nxt;
    r1_r       <= r1_nxt;
    t_r        <= t_nxt;
    b_r        <= b_nxt;
    t1_r       <= t1_nxt;
    b1_r       <= b1_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/rectangle_raster_canvas.sv =====
// rectangle_raster_canvas: top level of the character canvas rasteriser
// depends on rrc_pkg, rrc_front, rrc_fifo, rrc_back and rrc_ram
//
//  channel  ports                          handshake
//  -------  -----------------------------  ------------------------------------
//  input    start, busy, in_item           word taken when start high, busy low
//  result   out_valid, out_item            one-cycle strobe, no back-pressure
//  config   cfg_we, cfg_index, cfg_data    written on any edge with cfg_we high
//
// a clear or a draw sweeps the active width x height area at one cell per
// cycle in the back end, then registers its result;
// a read passes the queue, the registered ram read and the result register;
// failed draws, reads outside the canvas and unused codes skip the ram read
// busy rises only when the two-entry command queue is full
// synchronous active-low reset; the canvas ram is not cleared and holds
// garbage until the first clear; the result side cannot stall
module rectangle_raster_canvas #(
  parameter int MAX_SIDE  = rrc_pkg::DEFAULT_MAX_SIDE,
  parameter int FRAC_BITS = rrc_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  rrc_pkg::rrc_in_t                 in_item,
  output logic                             out_valid,
  output rrc_pkg::rrc_out_t                out_item,
  input  logic                             cfg_we,
  input  logic [rrc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import rrc_pkg::*;

  localparam int CNT_W = $clog2(MAX_SIDE + 1);
  localparam int AW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE * MAX_SIDE) : 1;

  // configuration registers
  logic [9:0]       width_r;
  logic [9:0]       height_r;
  logic [7:0]       bg_r;
  logic [CNT_W-1:0] act_w, act_h;

  // queue between front and back
  logic     q_push, q_pop, q_empty, q_full;
  rrc_cmd_t q_cmd, q_head;

  // canvas ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RESET_CANVAS_WIDTH;
      height_r <= RESET_CANVAS_HEIGHT;
      bg_r     <= RESET_BACKGROUND;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CANVAS_WIDTH:    width_r  <= cfg_data;
        CFG_CANVAS_HEIGHT:   height_r <= cfg_data;
        CFG_BACKGROUND_CHAR: bg_r     <= cfg_data[7:0];
        default: begin
          // index beyond the register list: dropped
        end
      endcase
    end
  end

  // sizes beyond the canvas store saturate to its side
  assign act_w = (32'(width_r) > 32'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(width_r);
  assign act_h = (32'(height_r) > 32'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : CNT_W'(height_r);

  assign busy = q_full;

  rrc_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .act_w   (act_w),
    .act_h   (act_h),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  rrc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  rrc_back #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .act_w     (act_w),
    .act_h     (act_h),
    .bg_char   (bg_r),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // canvas store, row-major with a row pitch of the full side
  rrc_ram #(
    .WIDTH (8),
    .DEPTH (MAX_SIDE * MAX_SIDE)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // a failed or ignored draw always reports the sticky flag set
  a_fail_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status == ST_DRAW_FAIL |-> out_item.error_seen)
    else $error("draw failure reported without sticky flag");

  // only an in-range read may return a non-zero byte
  a_read_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != ST_OK |-> out_item.cell_value == 8'd0)
    else $error("non-zero cell value with error status");

  // a result is never shown in a cycle where the sweep still writes
  a_no_write_at_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !ram_we)
    else $error("canvas written while a result is shown");

  // a canvas read is answered through the S_READ state and the result register
  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> ##2 out_valid)
    else $error("canvas read without a result");

endmodule
